// ===== hdl/fcge_pkg.sv =====
// ----------------------------------------------------------------------------
// fcge_pkg
// shared types and constants for the fifo/clock/ghost replacement block
// ----------------------------------------------------------------------------
package fcge_pkg;

    localparam int ENTRIES   = 1024;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int PTR_W     = IDX_W + 1;
    localparam int KEY_BITS  = 64;
    localparam int SIZE_W    = 21;
    localparam int CFG_W     = 32;
    localparam int BYTES_W   = 33;
    localparam int CNT_W     = IDX_W + 1;
    localparam int CQ_DEPTH  = 2;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

    localparam logic [2:0] REG_CAPACITY = 3'd0;
    localparam logic [2:0] REG_FIFO_BUD = 3'd1;
    localparam logic [2:0] REG_CLK_BUD  = 3'd2;
    localparam logic [2:0] REG_GHO_BUD  = 3'd3;
    localparam logic [2:0] REG_LAZY     = 3'd4;
    localparam logic [2:0] REG_META     = 3'd5;

    localparam logic [1:0] QID_FREE  = 2'd0;
    localparam logic [1:0] QID_FIFO  = 2'd1;
    localparam logic [1:0] QID_CLOCK = 2'd2;
    localparam logic [1:0] QID_GHOST = 2'd3;

    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic                remove;
        logic [KEY_BITS-1:0] key;
        logic [SIZE_W-1:0]   size;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic ghost_hit;
        logic removed;
        logic table_overflow;
    } res_t;

    typedef struct packed {
        logic [CFG_W-1:0] capacity;
        logic [CFG_W-1:0] fifo_budget;
        logic [CFG_W-1:0] clock_budget;
        logic [CFG_W-1:0] ghost_budget;
        logic             lazy;
        logic             meta;
    } cfg_t;

endpackage

// ===== hdl/fcge_front.sv =====
// ----------------------------------------------------------------------------
// fcge_front
// request intake and short command queue feeding the policy engine
// ----------------------------------------------------------------------------
module fcge_front
    import fcge_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                req_type,
    input  logic [KEY_BITS-1:0] object_key,
    input  logic [SIZE_W-1:0]   object_size,
    output logic                cmd_valid,
    output cmd_t                cmd,
    input  logic                cmd_take
);

    cmd_t                 q_reg [CQ_DEPTH];
    logic [CQ_DEPTH-1:0]  v_reg;
    logic [CQ_DEPTH-1:0]  v_next;
    logic                 wr_reg;
    logic                 rd_reg;
    logic                 wr_en;
    logic                 rd_en;

    assign full      = v_reg[wr_reg];
    assign cmd_valid = v_reg[rd_reg];
    assign cmd       = q_reg[rd_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    always_comb
    begin
        v_next = v_reg;
        if (wr_en)
            v_next[wr_reg] = 1'b1;
        if (rd_en)
            v_next[rd_reg] = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_reg].remove <= (req_type == REQ_REMOVE);
            q_reg[wr_reg].key    <= object_key;
            q_reg[wr_reg].size   <= object_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
            if (wr_en)
                wr_reg <= ~wr_reg;
            if (rd_en)
                rd_reg <= ~rd_reg;
        end
    end

endmodule

// ===== hdl/fcge_engine.sv =====
// ----------------------------------------------------------------------------
// fcge_engine
// sequencer that walks the linked entry table: lookup, removal, eviction, insert
// ----------------------------------------------------------------------------
module fcge_engine
    import fcge_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_take,
    output logic        res_valid,
    output res_t        res,
    input  logic        res_take
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_SCAN_CHK, S_DISPATCH,
        S_UNL_RD, S_UNL_P, S_UNL_N,
        S_PUSH_RD, S_PUSH_H, S_PUSH_W,
        S_EV_LOOP, S_EV_F, S_CK_LOOP, S_CK_RD, S_CK_CHK,
        S_GH_LOOP, S_FREE_SCAN, S_FREE_CHK, S_RESULT
    } state_t;

    typedef enum logic [3:0] {
        K_NONE, K_HITF_PROMO, K_PROMO_DONE, K_GHOST_DONE, K_REMOVE_DONE,
        K_EVF_DEMOTE, K_DEMOTE_DONE, K_CK_DONE, K_GH_DONE, K_INSERT_DONE
    } cont_t;

    // entry memories
    logic [KEY_BITS-1:0] key_mem  [ENTRIES];
    logic [SIZE_W-1:0]   size_mem [ENTRIES];
    logic [1:0]          qid_mem  [ENTRIES];
    logic                ref_mem  [ENTRIES];
    logic [PTR_W-1:0]    prev_mem [ENTRIES];
    logic [PTR_W-1:0]    next_mem [ENTRIES];

    state_t              state_reg;
    cont_t               ret_reg;
    cont_t               pret_reg;
    cmd_t                cmd_reg;
    logic [IDX_W:0]      scan_reg;
    logic [IDX_W-1:0]    ent_reg;
    logic [IDX_W-1:0]    pe_reg;
    logic [SIZE_W-1:0]   psz_reg;
    logic [1:0]          pq_reg;
    logic [1:0]          uq_reg;
    logic [PTR_W-1:0]    up_reg;
    logic [PTR_W-1:0]    un_reg;
    logic [SIZE_W-1:0]   usz_reg;
    logic [PTR_W-1:0]    head_reg [3];
    logic [PTR_W-1:0]    tail_reg [3];
    logic [BYTES_W-1:0]  bytes_reg [3];
    logic [CNT_W-1:0]    cnt_reg [3];
    logic [PTR_W-1:0]    hand_reg;
    logic [PTR_W-1:0]    hp_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    fnd_reg;
    logic [1:0]          fq_reg;
    logic [SIZE_W-1:0]   need_reg;
    logic                rd_ref_reg;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [1:0]          rd_qid_reg;
    logic [1:0]          rd_eqid_reg;
    logic [PTR_W-1:0]    rd_prev_reg;
    logic [PTR_W-1:0]    rd_next_reg;
    logic [SIZE_W-1:0]   rd_size_reg;
    res_t                res_reg;
    logic                rv_reg;

    logic [IDX_W-1:0]    scan_idx;
    logic [BYTES_W:0]    resident_need;
    logic [PTR_W-1:0]    ck_tail;

    assign scan_idx      = scan_reg[IDX_W-1:0];
    assign resident_need = {1'b0, bytes_reg[0]} + {1'b0, bytes_reg[1]}
                         + (BYTES_W+1)'(need_reg);
    assign ck_tail       = tail_reg[1];
    assign cmd_take      = (state_reg == S_IDLE) && !rv_reg;
    assign res_valid     = rv_reg;
    assign res           = res_reg;

    // queue index from queue id
    function automatic logic [1:0] qn(input logic [1:0] id);
        qn = id - 2'd1;
    endfunction

    always_ff @(posedge clk)
    begin
        rd_key_reg  <= key_mem[scan_idx];
        rd_qid_reg  <= qid_mem[scan_idx];
        rd_eqid_reg <= qid_mem[ent_reg];
        rd_ref_reg  <= ref_mem[ent_reg];
        rd_prev_reg <= prev_mem[ent_reg];
        rd_next_reg <= next_mem[ent_reg];
        rd_size_reg <= size_mem[ent_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= K_NONE;
            pret_reg  <= K_NONE;
            scan_reg  <= '0;
            hand_reg  <= NIL;
            rv_reg    <= 1'b0;
            res_reg   <= '0;
            found_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                head_reg[i]  <= NIL;
                tail_reg[i]  <= NIL;
                bytes_reg[i] <= '0;
                cnt_reg[i]   <= '0;
            end
        end
        else
        begin
            if (rv_reg && res_take)
                rv_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    qid_mem[scan_idx] <= QID_FREE;
                    if (scan_reg == (IDX_W+1)'(ENTRIES - 1))
                        state_reg <= S_IDLE;
                    scan_reg <= scan_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (cmd_valid && !rv_reg)
                    begin
                        cmd_reg   <= cmd;
                        need_reg  <= cmd.size + SIZE_W'(cfg.meta);
                        res_reg   <= '0;
                        found_reg <= 1'b0;
                        scan_reg  <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    ent_reg   <= scan_idx;
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    if (rd_qid_reg != QID_FREE && rd_key_reg == cmd_reg.key)
                    begin
                        found_reg <= 1'b1;
                        fnd_reg   <= ent_reg;
                        fq_reg    <= rd_qid_reg;
                        state_reg <= S_DISPATCH;
                    end
                    else if (scan_reg == (IDX_W+1)'(ENTRIES - 1))
                        state_reg <= S_DISPATCH;
                    else
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_DISPATCH:
                begin
                    ent_reg <= fnd_reg;
                    if (cmd_reg.remove)
                    begin
                        if (found_reg)
                        begin
                            res_reg.removed <= 1'b1;
                            ret_reg         <= K_REMOVE_DONE;
                            state_reg       <= S_UNL_RD;
                        end
                        else
                        begin
                            rv_reg    <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (found_reg && fq_reg != QID_GHOST)
                    begin
                        res_reg.hit     <= 1'b1;
                        ref_mem[fnd_reg] <= 1'b1;
                        if (fq_reg == QID_FIFO && !cfg.lazy)
                        begin
                            ret_reg   <= K_HITF_PROMO;
                            state_reg <= S_UNL_RD;
                        end
                        else
                        begin
                            rv_reg    <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (found_reg)
                    begin
                        res_reg.ghost_hit <= 1'b1;
                        ret_reg           <= K_GHOST_DONE;
                        state_reg         <= S_UNL_RD;
                    end
                    else
                        state_reg <= S_EV_LOOP;
                end
                // unlink ent_reg
                S_UNL_RD:
                begin
                    state_reg <= S_UNL_P;
                end
                S_UNL_P:
                begin
                    uq_reg  <= qn(rd_eqid_reg);
                    up_reg  <= rd_prev_reg;
                    un_reg  <= rd_next_reg;
                    usz_reg <= rd_size_reg;
                    if (rd_prev_reg != NIL)
                        next_mem[rd_prev_reg[IDX_W-1:0]] <= rd_next_reg;
                    else
                        head_reg[qn(rd_eqid_reg)] <= rd_next_reg;
                    if (ret_reg == K_REMOVE_DONE && rd_eqid_reg == QID_CLOCK
                        && hand_reg == PTR_W'(ent_reg))
                        hand_reg <= rd_prev_reg;
                    state_reg <= S_UNL_N;
                end
                S_UNL_N:
                begin
                    if (un_reg != NIL)
                        prev_mem[un_reg[IDX_W-1:0]] <= up_reg;
                    else
                        tail_reg[uq_reg] <= up_reg;
                    bytes_reg[uq_reg] <= bytes_reg[uq_reg] - BYTES_W'(usz_reg);
                    cnt_reg[uq_reg]   <= cnt_reg[uq_reg] - 1'b1;
                    qid_mem[ent_reg]  <= QID_FREE;
                    case (ret_reg)
                        K_HITF_PROMO:
                        begin
                            ref_mem[ent_reg] <= 1'b0;
                            pe_reg <= ent_reg; pq_reg <= 2'd1; pret_reg <= K_PROMO_DONE;
                            psz_reg   <= usz_reg;
                            state_reg <= S_PUSH_RD;
                        end
                        K_EVF_DEMOTE:
                        begin
                            pe_reg    <= ent_reg;
                            psz_reg   <= usz_reg;
                            state_reg <= S_PUSH_RD;
                            if (cfg.lazy && rd_ref_reg)
                            begin
                                ref_mem[ent_reg] <= 1'b0;
                                pq_reg <= 2'd1; pret_reg <= K_PROMO_DONE;
                            end
                            else
                            begin
                                pq_reg <= 2'd2; pret_reg <= K_DEMOTE_DONE;
                            end
                        end
                        K_GHOST_DONE:  state_reg <= S_EV_LOOP;
                        K_REMOVE_DONE:
                        begin
                            rv_reg    <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        K_CK_DONE:
                            state_reg <= (pret_reg == K_CK_DONE) ? S_CK_LOOP : S_EV_LOOP;
                        K_GH_DONE:     state_reg <= S_GH_LOOP;
                        default:       state_reg <= S_EV_LOOP;
                    endcase
                end
                // push pe_reg at head of pq_reg
                S_PUSH_RD:
                begin
                    hp_reg    <= head_reg[pq_reg];
                    state_reg <= S_PUSH_H;
                end
                S_PUSH_H:
                begin
                    prev_mem[pe_reg] <= NIL;
                    next_mem[pe_reg] <= hp_reg;
                    if (hp_reg != NIL)
                        prev_mem[hp_reg[IDX_W-1:0]] <= PTR_W'(pe_reg);
                    else
                        tail_reg[pq_reg] <= PTR_W'(pe_reg);
                    head_reg[pq_reg] <= PTR_W'(pe_reg);
                    state_reg        <= S_PUSH_W;
                end
                S_PUSH_W:
                begin
                    bytes_reg[pq_reg] <= bytes_reg[pq_reg] + BYTES_W'(psz_reg);
                    cnt_reg[pq_reg]   <= cnt_reg[pq_reg] + 1'b1;
                    qid_mem[pe_reg]   <= pq_reg + 2'd1;
                    case (pret_reg)
                        K_PROMO_DONE:  state_reg <= S_CK_LOOP;
                        K_DEMOTE_DONE: state_reg <= S_GH_LOOP;
                        default:
                        begin
                            rv_reg    <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                // clock trim after promotion
                S_CK_LOOP:
                begin
                    if (bytes_reg[1] > BYTES_W'(cfg.clock_budget) && cnt_reg[1] != '0)
                    begin
                        ent_reg   <= (hand_reg == NIL) ? ck_tail[IDX_W-1:0]
                                                       : hand_reg[IDX_W-1:0];
                        ret_reg   <= K_CK_DONE;
                        pret_reg  <= K_CK_DONE;
                        state_reg <= S_CK_RD;
                    end
                    else if (res_reg.hit)
                    begin
                        rv_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_EV_LOOP;
                end
                S_CK_RD:
                    state_reg <= S_CK_CHK;
                S_CK_CHK:
                begin
                    if (rd_ref_reg)
                    begin
                        ref_mem[ent_reg] <= 1'b0;
                        ent_reg   <= (rd_prev_reg == NIL) ? ck_tail[IDX_W-1:0]
                                                          : rd_prev_reg[IDX_W-1:0];
                        state_reg <= S_CK_RD;
                    end
                    else
                    begin
                        hand_reg  <= rd_prev_reg;
                        state_reg <= S_UNL_RD;
                    end
                end
                // ghost trim
                S_GH_LOOP:
                begin
                    if (bytes_reg[2] > BYTES_W'(cfg.ghost_budget) && tail_reg[2] != NIL)
                    begin
                        ent_reg   <= tail_reg[2][IDX_W-1:0];
                        ret_reg   <= K_GH_DONE;
                        state_reg <= S_UNL_RD;
                    end
                    else
                        state_reg <= S_EV_LOOP;
                end
                // eviction loop for the pending insert
                S_EV_LOOP:
                begin
                    if (need_reg > cfg.capacity[SIZE_W-1:0] && cfg.capacity < 32'(1 << SIZE_W))
                    begin
                        rv_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (resident_need > (BYTES_W+1)'(cfg.capacity)
                             && (cnt_reg[0] != '0 || cnt_reg[1] != '0))
                    begin
                        state_reg <= S_EV_F;
                    end
                    else
                    begin
                        scan_reg  <= '0;
                        state_reg <= S_FREE_SCAN;
                    end
                end
                S_EV_F:
                begin
                    if (bytes_reg[0] > BYTES_W'(cfg.fifo_budget) || cnt_reg[1] == '0)
                    begin
                        if (tail_reg[0] == NIL)
                            state_reg <= S_EV_LOOP;
                        else
                        begin
                            ent_reg   <= tail_reg[0][IDX_W-1:0];
                            ret_reg   <= K_EVF_DEMOTE;
                            state_reg <= S_UNL_RD;
                        end
                    end
                    else
                    begin
                        ent_reg   <= (hand_reg == NIL) ? ck_tail[IDX_W-1:0]
                                                       : hand_reg[IDX_W-1:0];
                        ret_reg   <= K_CK_DONE;
                        pret_reg  <= K_NONE;
                        state_reg <= S_CK_RD;
                    end
                end
                S_FREE_SCAN:
                begin
                    state_reg <= S_FREE_CHK;
                end
                S_FREE_CHK:
                begin
                    if (rd_qid_reg == QID_FREE)
                    begin
                        key_mem[scan_idx]  <= cmd_reg.key;
                        size_mem[scan_idx] <= need_reg;
                        ref_mem[scan_idx]  <= 1'b0;
                        pe_reg    <= scan_idx;
                        psz_reg   <= need_reg;
                        pq_reg    <= res_reg.ghost_hit ? 2'd1 : 2'd0;
                        pret_reg  <= K_INSERT_DONE;
                        state_reg <= S_PUSH_RD;
                    end
                    else if (scan_reg == (IDX_W+1)'(ENTRIES - 1))
                    begin
                        res_reg.table_overflow <= 1'b1;
                        rv_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_FREE_SCAN;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/fifo_clock_ghost_eviction.sv =====
// ----------------------------------------------------------------------------
// fifo_clock_ghost_eviction
// byte-budgeted fifo / ghost / clock cache replacement policy
// ----------------------------------------------------------------------------
// operation: a key scan over all ENTRIES slots, then eviction steps as needed,
// and a free-slot scan over the entry table on insert
// throughput: one beat at a time through the table sequencer
// reset: a clearing pass over all ENTRIES slots frees every slot, no beat taken
// ----------------------------------------------------------------------------
module fifo_clock_ghost_eviction
    import fcge_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                push,
    output logic                full,
    input  logic                req_type,
    input  logic [KEY_BITS-1:0] object_key,
    input  logic [SIZE_W-1:0]   object_size,
    output logic                empty,
    input  logic                pop,
    output logic                hit,
    output logic                ghost_hit,
    output logic                removed,
    output logic                table_overflow
);

    cfg_t cfg_reg;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;
    logic res_valid;
    res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity     <= 32'd1048576;
            cfg_reg.fifo_budget  <= 32'd209715;
            cfg_reg.clock_budget <= 32'd838861;
            cfg_reg.ghost_budget <= 32'd838861;
            cfg_reg.lazy         <= 1'b1;
            cfg_reg.meta         <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAPACITY: cfg_reg.capacity     <= cfg_data;
                REG_FIFO_BUD: cfg_reg.fifo_budget  <= cfg_data;
                REG_CLK_BUD:  cfg_reg.clock_budget <= cfg_data;
                REG_GHO_BUD:  cfg_reg.ghost_budget <= cfg_data;
                REG_LAZY:     cfg_reg.lazy         <= cfg_data[0];
                REG_META:     cfg_reg.meta         <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    fcge_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .object_key  (object_key),
        .object_size (object_size),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take)
    );

    fcge_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (pop)
    );

    assign empty          = !res_valid;
    assign hit            = res.hit;
    assign ghost_hit      = res.ghost_hit;
    assign removed        = res.removed;
    assign table_overflow = res.table_overflow;

endmodule

// ===== sim/fifo_clock_ghost_eviction_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_clock_ghost_eviction_tb
// Self-checking bench for the fifo / ghost / clock replacement block. Requests
// go in through the push side. A behavioural copy of the policy predicts each
// result beat. A separate popping process compares every beat with the oldest
// prediction. Directed tests cover hits, ghost hits, removes, oversize
// objects and a full entry table. A long output hold-off fills the block.
// Random phases then run under several register settings.
// ----------------------------------------------------------------------------
module fifo_clock_ghost_eviction_tb;
    import fcge_pkg::*;

    localparam int  NIL_IDX = ENTRIES;
    localparam int  Q_FIFO  = 0;
    localparam int  Q_CLOCK = 1;
    localparam int  Q_GHOST = 2;
    localparam longint CYCLE_LIMIT = 64'd80_000_000;
    localparam int  HOLD_CYCLES = 40000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                push = 1'b0;
    logic                full;
    logic                req_type = REQ_ACCESS;
    logic [KEY_BITS-1:0] object_key = '0;
    logic [SIZE_W-1:0]   object_size = SIZE_W'(1);
    logic                empty;
    logic                pop = 1'b0;
    logic                hit;
    logic                ghost_hit;
    logic                removed;
    logic                table_overflow;

    fifo_clock_ghost_eviction dut (.*);

    always #2 clk = ~clk;

    // policy state
    logic [CFG_W-1:0]    capacity_r, fifo_bud_r, clock_bud_r, ghost_bud_r;
    logic                lazy_r, meta_r;
    logic [KEY_BITS-1:0] slot_key  [ENTRIES];
    int unsigned         slot_size [ENTRIES];
    logic [1:0]          slot_qid  [ENTRIES];
    bit                  slot_mark [ENTRIES];
    int                  slot_prev [ENTRIES];
    int                  slot_next [ENTRIES];
    int                  q_head [3];
    int                  q_tail [3];
    longint              q_bytes [3];
    int                  q_objs [3];
    int                  hand;

    res_t                pending_res [$];
    logic [KEY_BITS-1:0] key_pool [64];
    longint              cycles = 0;
    int                  errors = 0;
    int                  beats_seen = 0;
    int                  n_hit = 0, n_ghost = 0, n_removed = 0, n_ovf = 0;
    bit                  no_idle = 1'b0;
    int                  hold_req = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                     pending_res.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic void policy_reset();
        capacity_r  = 32'd1048576;
        fifo_bud_r  = 32'd209715;
        clock_bud_r = 32'd838861;
        ghost_bud_r = 32'd838861;
        lazy_r = 1'b1;
        meta_r = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_qid[i]  = QID_FREE;
            slot_mark[i] = 1'b0;
            slot_prev[i] = NIL_IDX;
            slot_next[i] = NIL_IDX;
        end
        for (int q = 0; q < 3; q++)
        begin
            q_head[q] = NIL_IDX;
            q_tail[q] = NIL_IDX;
            q_bytes[q] = 0;
            q_objs[q] = 0;
        end
        hand = NIL_IDX;
    endfunction

    function automatic void unlink(int e);
        int q, p, n;
        q = int'(slot_qid[e]) - 1;
        p = slot_prev[e];
        n = slot_next[e];
        if (p != NIL_IDX) slot_next[p] = n; else q_head[q] = n;
        if (n != NIL_IDX) slot_prev[n] = p; else q_tail[q] = p;
        q_bytes[q] -= slot_size[e];
        q_objs[q]--;
        slot_qid[e] = QID_FREE;
    endfunction

    function automatic void link_head(int e, int q);
        int h;
        h = q_head[q];
        slot_prev[e] = NIL_IDX;
        slot_next[e] = h;
        if (h != NIL_IDX) slot_prev[h] = e; else q_tail[q] = e;
        q_head[q] = e;
        q_bytes[q] += slot_size[e];
        q_objs[q]++;
        slot_qid[e] = 2'(q + 1);
    endfunction

    function automatic void drop_slot(int e);
        if (slot_qid[e] == QID_CLOCK && hand == e)
            hand = slot_prev[e];
        unlink(e);
    endfunction

    function automatic void sweep_clock();
        int t, p;
        t = q_tail[Q_CLOCK];
        p = hand;
        if (t == NIL_IDX) return;
        if (p == NIL_IDX) p = t;
        while (slot_mark[p])
        begin
            slot_mark[p] = 1'b0;
            p = slot_prev[p];
            if (p == NIL_IDX) p = t;
        end
        hand = slot_prev[p];
        unlink(p);
    endfunction

    function automatic void trim_clock();
        while (q_bytes[Q_CLOCK] > longint'(clock_bud_r) && q_objs[Q_CLOCK] > 0)
            sweep_clock();
    endfunction

    function automatic void make_room_step();
        int e;
        if (q_bytes[Q_FIFO] > longint'(fifo_bud_r) || q_objs[Q_CLOCK] == 0)
        begin
            e = q_tail[Q_FIFO];
            if (e == NIL_IDX) return;
            unlink(e);
            if (lazy_r && slot_mark[e])
            begin
                slot_mark[e] = 1'b0;
                link_head(e, Q_CLOCK);
                trim_clock();
            end
            else
            begin
                link_head(e, Q_GHOST);
                while (q_bytes[Q_GHOST] > longint'(ghost_bud_r) && q_tail[Q_GHOST] != NIL_IDX)
                    drop_slot(q_tail[Q_GHOST]);
            end
        end
        else
            sweep_clock();
    endfunction

    function automatic res_t lookup_and_update(logic rt, logic [KEY_BITS-1:0] key,
                                               logic [SIZE_W-1:0] size);
        res_t r;
        int e, s;
        longint need;
        r = '0;
        e = NIL_IDX;
        for (int i = 0; i < ENTRIES; i++)
            if (e == NIL_IDX && slot_qid[i] != QID_FREE && slot_key[i] == key) e = i;
        if (rt == REQ_REMOVE)
        begin
            if (e != NIL_IDX)
            begin
                drop_slot(e);
                r.removed = 1'b1;
            end
            return r;
        end
        need = longint'(size) + longint'(meta_r);
        if (e != NIL_IDX)
        begin
            if (slot_qid[e] == QID_FIFO)
            begin
                r.hit = 1'b1;
                slot_mark[e] = 1'b1;
                if (!lazy_r)
                begin
                    unlink(e);
                    slot_mark[e] = 1'b0;
                    link_head(e, Q_CLOCK);
                    trim_clock();
                end
            end
            else if (slot_qid[e] == QID_CLOCK)
            begin
                r.hit = 1'b1;
                slot_mark[e] = 1'b1;
            end
            else
            begin
                drop_slot(e);
                r.ghost_hit = 1'b1;
            end
        end
        if (!r.hit && need <= longint'(capacity_r))
        begin
            while (q_bytes[Q_FIFO] + q_bytes[Q_CLOCK] + need > longint'(capacity_r)
                   && q_objs[Q_FIFO] + q_objs[Q_CLOCK] > 0)
                make_room_step();
            s = NIL_IDX;
            for (int i = ENTRIES - 1; i >= 0; i--)
                if (slot_qid[i] == QID_FREE) s = i;
            if (s == NIL_IDX)
                r.table_overflow = 1'b1;
            else
            begin
                slot_key[s]  = key;
                slot_size[s] = int'(need);
                slot_mark[s] = 1'b0;
                link_head(s, r.ghost_hit ? Q_CLOCK : Q_FIFO);
            end
        end
        return r;
    endfunction

    // one request beat, prediction taken at acceptance
    task automatic send_req(logic rt, logic [KEY_BITS-1:0] key, logic [SIZE_W-1:0] size);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        req_type    <= rt;
        object_key  <= key;
        object_size <= size;
        @(negedge clk);
        while (full) @(negedge clk);
        @(posedge clk);
        pending_res.push_back(lookup_and_update(rt, key, size));
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CAPACITY: capacity_r  = val;
            REG_FIFO_BUD: fifo_bud_r  = val;
            REG_CLK_BUD:  clock_bud_r = val;
            REG_GHO_BUD:  ghost_bud_r = val;
            REG_LAZY:     lazy_r = val[0];
            REG_META:     meta_r = val[0];
            default: ;
        endcase
    endtask

    task automatic set_policy(logic [CFG_W-1:0] cap, logic [CFG_W-1:0] fb,
                              logic [CFG_W-1:0] cb, logic [CFG_W-1:0] gb,
                              logic lz, logic md);
        drain();
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_FIFO_BUD, fb);
        write_reg(REG_CLK_BUD, cb);
        write_reg(REG_GHO_BUD, gb);
        write_reg(REG_LAZY, {$urandom_range(0, 32'h7fff_ffff), lz});
        write_reg(REG_META, {$urandom_range(0, 32'h7fff_ffff), md});
        @(posedge clk);
    endtask

    // result side
    initial
    begin
        int gap;
        res_t want;
        @(posedge rst_n);
        forever
        begin
            if (hold_req > 0)
            begin
                pop <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end
            gap = draw_gap();
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(negedge clk);
            while (empty) @(negedge clk);
            beats_seen++;
            if (pending_res.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: hit=%b ghost=%b rem=%b ovf=%b",
                             hit, ghost_hit, removed, table_overflow);
            end
            else
            begin
                want = pending_res.pop_front();
                n_hit     += want.hit;
                n_ghost   += want.ghost_hit;
                n_removed += want.removed;
                n_ovf     += want.table_overflow;
                if (hit !== want.hit || ghost_hit !== want.ghost_hit ||
                    removed !== want.removed || table_overflow !== want.table_overflow)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("beat %0d mismatch: exp h/g/r/o=%b%b%b%b got %b%b%b%b",
                                 beats_seen, want.hit, want.ghost_hit, want.removed,
                                 want.table_overflow, hit, ghost_hit, removed,
                                 table_overflow);
                end
            end
            @(posedge clk);
        end
    end

    task automatic test_directed();
        logic [KEY_BITS-1:0] k;
        k = {$urandom, $urandom};
        send_req(REQ_ACCESS, k, SIZE_W'(1));
        send_req(REQ_ACCESS, k, SIZE_W'(1));
        send_req(REQ_REMOVE, k, SIZE_W'(5));
        send_req(REQ_REMOVE, k, SIZE_W'(5));
        send_req(REQ_ACCESS, '0, SIZE_W'(1048576));
        send_req(REQ_ACCESS, '1, SIZE_W'(1048576));
        send_req(REQ_ACCESS, '0, SIZE_W'(7));
        set_policy(32'd1048576, 32'd209715, 32'd838861, 32'd838861, 1'b1, 1'b1);
        send_req(REQ_ACCESS, 64'h5555_aaaa_5555_aaaa, SIZE_W'(1048576));
        drain();
        write_reg(3'd6, '1);
        write_reg(3'd7, '0);
        // small cache: demotion to ghost, ghost hit, removal from the clock queue
        set_policy(32'd12, 32'd2, 32'd9, 32'd9, 1'b1, 1'b0);
        for (int i = 1; i <= 5; i++)
            send_req(REQ_ACCESS, 64'(i), SIZE_W'(3));
        send_req(REQ_ACCESS, 64'd1, SIZE_W'(3));
        send_req(REQ_ACCESS, 64'd2, SIZE_W'(3));
        send_req(REQ_ACCESS, 64'd1, SIZE_W'(3));
        send_req(REQ_REMOVE, 64'd1, SIZE_W'(3));
        send_req(REQ_REMOVE, 64'd3, SIZE_W'(3));
        set_policy(32'd12, 32'd2, 32'd9, 32'd9, 1'b0, 1'b0);
        send_req(REQ_ACCESS, 64'd5, SIZE_W'(3));
        send_req(REQ_ACCESS, 64'd5, SIZE_W'(3));
        send_req(REQ_ACCESS, 64'd9, SIZE_W'(13));
    endtask

    task automatic test_table_full();
        set_policy('1, '1, '1, '1, 1'b1, 1'b0);
        no_idle = 1'b1;
        for (int i = 0; i < ENTRIES + 3; i++)
            send_req(REQ_ACCESS, 64'h1000 + 64'(i), SIZE_W'(1));
        send_req(REQ_REMOVE, 64'h1000 + 64'd7, SIZE_W'(1));
        send_req(REQ_ACCESS, 64'h9999, SIZE_W'(1));
        send_req(REQ_ACCESS, 64'h999a, SIZE_W'(1));
        no_idle = 1'b0;
        drain();
    endtask

    task automatic test_backpressure();
        set_policy(32'd1000, 32'd200, 32'd800, 32'd800, 1'b1, 1'b0);
        drain();
        hold_req = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
            send_req(REQ_ACCESS, key_pool[i], SIZE_W'($urandom_range(1, 90)));
    endtask

    task automatic random_phase(int n, int max_size);
        logic [KEY_BITS-1:0] k;
        logic [SIZE_W-1:0] sz;
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
            k = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                               : key_pool[$urandom_range(0, 63)];
            if ($urandom_range(0, 49) == 0)
                sz = SIZE_W'($urandom_range(1, 1048576));
            else
                sz = SIZE_W'($urandom_range(1, max_size));
            send_req(($urandom_range(0, 6) == 0) ? REQ_REMOVE : REQ_ACCESS, k, sz);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        set_policy(32'd1000, 32'd200, 32'd800, 32'd800, 1'b1, 1'b0);
        random_phase(105, 60);
        set_policy(32'd1000, 32'd200, 32'd800, 32'd800, 1'b0, 1'b1);
        random_phase(105, 60);
        set_policy(32'd300, 32'd0, 32'd250, 32'd0, 1'b1, 1'b1);
        random_phase(105, 40);
        set_policy(32'd1, 32'd0, 32'd1, 32'd0, 1'b0, 1'b0);
        random_phase(105, 2);
        set_policy(32'd5000, 32'd1000, 32'd4000, 32'd4000, 1'b1, 1'b0);
        random_phase(105, 200);
        set_policy('1, '1, '1, '1, 1'b1, 1'b1);
        random_phase(105, 1048576);
        set_policy(32'd4096, 32'd4096, 32'd1, 32'd2000, 1'b0, 1'b0);
        random_phase(105, 300);
        set_policy(32'd2000, 32'd100, 32'd1800, 32'd3000, 1'b1, 1'b0);
        random_phase(105, 120);
    endtask

    initial
    begin
        policy_reset();
        for (int i = 0; i < 64; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random();
        drain();
        repeat (5000) @(posedge clk);
        $display("checked %0d result beats: %0d hits, %0d ghost hits, %0d removes",
                 beats_seen, n_hit, n_ghost, n_removed);
        $display("%0d table overflows, %0d mismatches, over eight register settings",
                 n_ovf, errors);
        if (errors == 0 && pending_res.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== fifo_clock_ghost_eviction.f =====
hdl/fcge_pkg.sv
hdl/fcge_front.sv
hdl/fcge_engine.sv
hdl/fifo_clock_ghost_eviction.sv
sim/fifo_clock_ghost_eviction_tb.sv
